### src/imapld_pkg.sv
package imapld_pkg;

    // Configuration register indexes.
    localparam logic REG_MAX_LINE    = 1'b0;
    localparam logic REG_MAX_MESSAGE = 1'b1;

    // Register reset values.
    localparam logic [15:0] MAX_LINE_RST    = 16'd8192;
    localparam logic [31:0] MAX_MESSAGE_RST = 32'd16777216;

    // Byte codes of interest.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Saturation limits of the digit accumulator and the line counter.
    localparam logic [32:0] DIGIT_SAT = 33'h1_0000_0000;
    localparam logic [16:0] LINE_SAT  = 17'h1_FFFF;

    // Kind of an output item.
    typedef enum logic [1:0] {
        KIND_LINE    = 2'd0,
        KIND_LITERAL = 2'd1,
        KIND_DROP    = 2'd2
    } t_kind;

    // Sticky failure code.
    typedef enum logic [1:0] {
        FAIL_NONE    = 2'd0,
        FAIL_LINE    = 2'd1,
        FAIL_LITERAL = 2'd2
    } t_fail;

    // Progress through the literal announcement at the end of a line.
    typedef enum logic [2:0] {
        SFX_NONE   = 3'd0,
        SFX_OPEN   = 3'd1,
        SFX_DIGITS = 3'd2,
        SFX_PLUS   = 3'd3,
        SFX_CLOSE  = 3'd4
    } t_sfx;

endpackage

### src/imap_line_literal_deframer.sv
// Splits an IMAP response byte stream into line bytes and literal bytes. Each
// input item yields exactly one registered output item, and one item can
// be accepted in every clock cycle: all per-byte work (suffix tracking, the
// multiply-by-ten digit update, counters and limit compares) sits between the
// line state registers and a single output register. That output register
// takes a new item whenever it is empty or its item is being taken in the same
// cycle, so s_axis_tready falls only while the output side stalls. A line
// longer than max_line bytes or a literal announcement above max_message sets
// a sticky failure; every later byte is passed as dropped until reset.
module imap_line_literal_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    // Output stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] literal_count
    output logic [4:0]  m_axis_tuser,   // [1:0] byte_kind, [2] literal_follows,
                                        // [4:3] error_code
    output logic        m_axis_tlast    // end_mark
);
    import imapld_pkg::*;

    // Configuration registers.
    logic [15:0] r_max_line;
    logic [31:0] r_max_message;

    // Line and literal state.
    logic        r_in_literal, n_in_literal;
    logic [31:0] r_literal_left, n_literal_left;
    logic [16:0] r_line_count, n_line_count;
    logic        r_prev_was_cr, n_prev_was_cr;
    logic        r_held_crlf, n_held_crlf;
    t_sfx        r_sfx, n_sfx;
    logic [32:0] r_digit, n_digit;
    t_fail       r_fail, n_fail;

    // Output register.
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    t_kind       r_kind, n_kind;
    logic        r_end_mark, n_end_mark;
    logic        r_follows, n_follows;
    logic [31:0] r_count, n_count;
    t_fail       r_err;

    logic        w_accept;
    logic [7:0]  w_byte;
    logic        w_is_cr, w_is_lf, w_is_digit;
    logic [36:0] w_digit_next;
    t_sfx        w_sfx_base;

    assign w_byte        = s_axis_tdata;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_is_cr    = (w_byte == CH_CR);
    assign w_is_lf    = (w_byte == CH_LF);
    assign w_is_digit = (w_byte >= CH_ZERO) && (w_byte <= CH_NINE);

    // Accumulator times ten plus the new digit.
    assign w_digit_next = {1'b0, r_digit, 3'b000} + {3'b000, r_digit, 1'b0}
                        + {29'd0, w_byte - CH_ZERO};

    // A CR or LF held inside the line breaks any announcement in progress.
    assign w_sfx_base = r_held_crlf ? SFX_NONE : r_sfx;

    // Next state of the line and literal tracking.
    always_comb begin
        n_in_literal   = r_in_literal;
        n_literal_left = r_literal_left;
        n_line_count   = r_line_count;
        n_prev_was_cr  = r_prev_was_cr;
        n_held_crlf    = r_held_crlf;
        n_sfx          = r_sfx;
        n_digit        = r_digit;
        n_fail         = r_fail;
        if (r_fail != FAIL_NONE) begin
            n_fail = r_fail;
        end else if (r_in_literal) begin
            n_literal_left = r_literal_left - 32'd1;
            if (n_literal_left == 32'd0) begin
                n_in_literal = 1'b0;
            end
        end else if (w_is_lf && r_prev_was_cr) begin
            if (r_sfx == SFX_CLOSE) begin
                if (r_digit > {1'b0, r_max_message}) begin
                    n_fail = FAIL_LITERAL;
                end else begin
                    n_literal_left = r_digit[31:0];
                    n_in_literal   = (r_digit[31:0] != 32'd0);
                end
            end
            n_line_count  = '0;
            n_prev_was_cr = 1'b0;
            n_held_crlf   = 1'b0;
            n_sfx         = SFX_NONE;
            n_digit       = '0;
        end else if (r_line_count >= {1'b0, r_max_line}) begin
            n_fail = FAIL_LINE;
        end else begin
            if (r_line_count < LINE_SAT) begin
                n_line_count = r_line_count + 17'd1;
            end
            n_prev_was_cr = w_is_cr;
            if (w_is_cr || w_is_lf) begin
                n_held_crlf = 1'b1;
            end else begin
                n_held_crlf = 1'b0;
                if (w_byte == CH_OPEN) begin
                    n_sfx   = SFX_OPEN;
                    n_digit = '0;
                end else if (w_is_digit) begin
                    if (w_sfx_base == SFX_OPEN || w_sfx_base == SFX_DIGITS) begin
                        n_sfx = SFX_DIGITS;
                        if (w_digit_next > {4'd0, DIGIT_SAT}) begin
                            n_digit = DIGIT_SAT;
                        end else begin
                            n_digit = w_digit_next[32:0];
                        end
                    end else begin
                        n_sfx = SFX_NONE;
                    end
                end else if (w_byte == CH_PLUS) begin
                    n_sfx = (w_sfx_base == SFX_DIGITS) ? SFX_PLUS : SFX_NONE;
                end else if (w_byte == CH_CLOSE) begin
                    n_sfx = (w_sfx_base == SFX_DIGITS || w_sfx_base == SFX_PLUS)
                          ? SFX_CLOSE : SFX_NONE;
                end else begin
                    n_sfx = SFX_NONE;
                end
            end
        end
    end

    // Result fields of the item being accepted.
    always_comb begin
        n_kind     = KIND_LINE;
        n_end_mark = 1'b0;
        n_follows  = 1'b0;
        n_count    = '0;
        if (r_fail != FAIL_NONE) begin
            n_kind = KIND_DROP;
        end else if (r_in_literal) begin
            n_kind     = KIND_LITERAL;
            n_end_mark = (r_literal_left == 32'd1);
        end else if (w_is_lf && r_prev_was_cr) begin
            if (r_sfx == SFX_CLOSE) begin
                if (r_digit > {1'b0, r_max_message}) begin
                    n_kind = KIND_DROP;
                end else begin
                    n_end_mark = 1'b1;
                    n_follows  = 1'b1;
                    n_count    = r_digit[31:0];
                end
            end else begin
                n_end_mark = 1'b1;
            end
        end else if (r_line_count >= {1'b0, r_max_line}) begin
            n_kind = KIND_DROP;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line    <= MAX_LINE_RST;
            r_max_message <= MAX_MESSAGE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_LINE:    r_max_line    <= i_cfg_data[15:0];
                REG_MAX_MESSAGE: r_max_message <= i_cfg_data;
                default:         r_max_line    <= r_max_line;
            endcase
        end
    end

    // State registers, advanced once per accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_literal   <= 1'b0;
            r_literal_left <= '0;
            r_line_count   <= '0;
            r_prev_was_cr  <= 1'b0;
            r_held_crlf    <= 1'b0;
            r_sfx          <= SFX_NONE;
            r_digit        <= '0;
            r_fail         <= FAIL_NONE;
        end else if (w_accept) begin
            r_in_literal   <= n_in_literal;
            r_literal_left <= n_literal_left;
            r_line_count   <= n_line_count;
            r_prev_was_cr  <= n_prev_was_cr;
            r_held_crlf    <= n_held_crlf;
            r_sfx          <= n_sfx;
            r_digit        <= n_digit;
            r_fail         <= n_fail;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_byte <= w_byte;
            r_kind     <= n_kind;
            r_end_mark <= n_end_mark;
            r_follows  <= n_follows;
            r_count    <= n_count;
            r_err      <= n_fail;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_count, r_out_byte};
    assign m_axis_tuser  = {r_err, r_follows, r_kind};
    assign m_axis_tlast  = r_end_mark;

`ifndef SYNTHESIS
    // A dropped item always carries a failure code.
    a_drop_has_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_DROP) |-> (r_err != FAIL_NONE))
        else $error("dropped item without failure code");

    // A literal announcement only comes on a line byte that ends the line.
    a_follows_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_follows) |-> (r_end_mark && r_kind == KIND_LINE))
        else $error("literal announcement away from line end");

    // Literal mode always has bytes left and never coexists with a failure.
    a_literal_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_literal |-> (r_literal_left != 32'd0 && r_fail == FAIL_NONE))
        else $error("literal mode with no bytes left or after failure");

    // A failure stays until reset.
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fail != FAIL_NONE) |=> (r_fail == $past(r_fail)))
        else $error("failure code changed");

    // The digit accumulator never passes its saturation value.
    a_digit_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_digit <= DIGIT_SAT)
        else $error("digit accumulator above saturation");
`endif

endmodule

### tb/imapld_frame_checker.sv
`timescale 1ns / 1ps

// Watches both streams of the deframer, tags every accepted input byte with
// its own line/literal tracker and compares each output item against the
// oldest tag still waiting.
module imapld_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration writes, as driven into the block.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // Input stream.
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    // Output stream.
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [39:0] i_out_data,  // [7:0] out_byte, [39:8] literal_count
    input  logic [4:0]  i_out_user,  // [1:0] byte_kind, [2] literal_follows,
                                     // [4:3] error_code
    input  logic        i_out_last,  // end_mark
    output int          o_pending,
    output int          o_fail_count
);
    import imapld_pkg::*;

    typedef struct packed {
        logic [7:0]  out_byte;
        t_kind       kind;
        logic        end_mark;
        logic        follows;
        logic [31:0] count;
        t_fail       err;
    } t_tagged;

    // Limits as last written.
    logic [15:0] lim_line;
    logic [31:0] lim_msg;

    // Framing state.
    logic        lit_active;
    logic [31:0] lit_left;
    logic [16:0] line_len;
    logic        last_cr;
    logic        trailing_crlf;
    t_sfx        sfx;
    logic [32:0] digits;
    t_fail       fail_st;

    t_tagged tagged_q[$];
    int      mismatches = 0;

    task clear_line;
        begin
            line_len      = '0;
            last_cr       = 1'b0;
            trailing_crlf = 1'b0;
            sfx           = SFX_NONE;
            digits        = '0;
        end
    endtask

    // Works out the tagged output for one byte and advances the framing state.
    task tag_byte(input logic [7:0] b, output t_tagged r);
        logic [63:0] acc;
        begin
            r.out_byte = b;
            r.kind     = KIND_LINE;
            r.end_mark = 1'b0;
            r.follows  = 1'b0;
            r.count    = '0;
            if (fail_st != FAIL_NONE) begin
                r.kind = KIND_DROP;
            end else if (lit_active) begin
                r.kind   = KIND_LITERAL;
                lit_left = lit_left - 1;
                if (lit_left == 0) begin
                    r.end_mark = 1'b1;
                    lit_active = 1'b0;
                end
            end else if (b == CH_LF && last_cr) begin
                // Line end: an announcement either opens a literal or fails.
                if (sfx == SFX_CLOSE) begin
                    if (digits > {1'b0, lim_msg}) begin
                        fail_st = FAIL_LITERAL;
                        r.kind  = KIND_DROP;
                    end else begin
                        r.end_mark = 1'b1;
                        r.follows  = 1'b1;
                        r.count    = digits[31:0];
                        lit_left   = digits[31:0];
                        lit_active = (digits[31:0] != 0);
                    end
                end else begin
                    r.end_mark = 1'b1;
                end
                clear_line();
            end else if (line_len >= {1'b0, lim_line}) begin
                fail_st = FAIL_LINE;
                r.kind  = KIND_DROP;
            end else begin
                if (line_len != LINE_SAT) line_len = line_len + 1;
                last_cr = (b == CH_CR);
                if (b == CH_CR || b == CH_LF) begin
                    trailing_crlf = 1'b1;
                end else begin
                    // Any other byte ends a run of trailing CR/LF bytes.
                    if (trailing_crlf) begin
                        sfx           = SFX_NONE;
                        trailing_crlf = 1'b0;
                    end
                    if (b == CH_OPEN) begin
                        sfx    = SFX_OPEN;
                        digits = '0;
                    end else if (b >= CH_ZERO && b <= CH_NINE) begin
                        if (sfx == SFX_OPEN || sfx == SFX_DIGITS) begin
                            acc = {31'd0, digits} * 64'd10 + {56'd0, b} - {56'd0, CH_ZERO};
                            digits = (acc > {31'd0, DIGIT_SAT}) ? DIGIT_SAT : acc[32:0];
                            sfx    = SFX_DIGITS;
                        end else begin
                            sfx = SFX_NONE;
                        end
                    end else if (b == CH_PLUS) begin
                        sfx = (sfx == SFX_DIGITS) ? SFX_PLUS : SFX_NONE;
                    end else if (b == CH_CLOSE) begin
                        sfx = (sfx == SFX_DIGITS || sfx == SFX_PLUS) ? SFX_CLOSE : SFX_NONE;
                    end else begin
                        sfx = SFX_NONE;
                    end
                end
            end
            r.err = fail_st;
        end
    endtask

    task check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        begin
            if (want !== got) begin
                $display("%t %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
                mismatches++;
            end
        end
    endtask

    // Outputs are compared before the input of the same edge is tagged, so an
    // output never meets a tag made in its own cycle.
    always @(posedge i_clk) begin : watch
        t_tagged want;
        if (!i_rst_n) begin
            lim_line   = MAX_LINE_RST;
            lim_msg    = MAX_MESSAGE_RST;
            lit_active = 1'b0;
            lit_left   = '0;
            fail_st    = FAIL_NONE;
            clear_line();
            tagged_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (tagged_q.size() == 0) begin
                    $display("%t output item 0x%0h/0x%0h with nothing expected",
                             $time, i_out_data, i_out_user);
                    mismatches++;
                end else begin
                    want = tagged_q.pop_front();
                    check_field("out_byte", 32'(want.out_byte), 32'(i_out_data[7:0]));
                    check_field("byte_kind", 32'(want.kind), 32'(i_out_user[1:0]));
                    check_field("end_mark", 32'(want.end_mark), 32'(i_out_last));
                    check_field("literal_follows", 32'(want.follows), 32'(i_out_user[2]));
                    check_field("literal_count", want.count, i_out_data[39:8]);
                    check_field("error_code", 32'(want.err), 32'(i_out_user[4:3]));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MAX_LINE) lim_line = i_cfg_data[15:0];
                else lim_msg = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                tag_byte(i_in_byte, want);
                tagged_q.push_back(want);
            end
        end
        o_pending    <= tagged_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb_imap_line_literal_deframer.sv
`timescale 1ns / 1ps

module tb_imap_line_literal_deframer;
    import imapld_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 260;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // [7:0] out_byte, [39:8] literal_count
    logic [4:0]  m_axis_tuser;   // [1:0] byte_kind, [2] literal_follows, [4:3] error_code
    logic        m_axis_tlast;   // end_mark

    int pending;
    int fail_count;
    int cycles = 0;
    int bytes_sent = 0;
    logic src_steady = 1'b0;

    // Limits currently programmed, used only to shape the traffic.
    logic [15:0] cur_max_line = MAX_LINE_RST;
    logic [31:0] cur_max_msg  = MAX_MESSAGE_RST;

    // Bytes of the next message, sent front to back.
    logic [7:0] line_bytes[$];

    always #5 i_clk = ~i_clk;

    imap_line_literal_deframer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    imapld_frame_checker frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_byte    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random byte that can never close a literal announcement.
    function automatic logic [7:0] noise_byte();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        if (r == CH_CLOSE) r = 8'h7C;
        return r;
    endfunction

    task send_byte(input logic [7:0] b);
        int gap;
        begin
            gap = src_steady ? 0 : idle_cycles();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= b;
            @(posedge i_clk);
            while (!s_axis_tready) @(posedge i_clk);
            bytes_sent++;
        end
    endtask

    task send_queue;
        begin
            foreach (line_bytes[i]) send_byte(line_bytes[i]);
            line_bytes.delete();
        end
    endtask

    task push_text(input string s);
        begin
            for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
        end
    endtask

    task push_decimal(input logic [63:0] v, input int zeros);
        logic [7:0] dg[0:20];
        int n;
        begin
            n = 0;
            while (v != 0 || n == 0) begin
                dg[n] = CH_ZERO + 8'(v % 64'd10);
                v     = v / 10;
                n++;
            end
            repeat (zeros) line_bytes.push_back(CH_ZERO);
            for (int i = n - 1; i >= 0; i--) line_bytes.push_back(dg[i]);
        end
    endtask

    task wait_drained;
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (pending != 0) @(posedge i_clk);
        end
    endtask

    // Both limits are rewritten only once every output item has been taken.
    task set_limits(input logic [15:0] line_lim, input logic [31:0] msg_lim);
        begin
            wait_drained();
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_MAX_LINE;
            i_cfg_data <= {16'd0, line_lim};
            @(posedge i_clk);
            i_cfg_idx  <= REG_MAX_MESSAGE;
            i_cfg_data <= msg_lim;
            @(posedge i_clk);
            i_cfg_we     <= 1'b0;
            cur_max_line = line_lim;
            cur_max_msg  = msg_lim;
        end
    endtask

    // One response line, kept below the line limit. Half of them announce a
    // literal within the message limit and carry it; the others are plain
    // text or announcements broken so that no literal follows.
    task send_message;
        int budget, room, cap, form, c, n;
        logic announced;
        begin
            src_steady = ($urandom_range(0, 9) == 0);
            budget     = int'(cur_max_line) - 1;
            cap        = ($urandom_range(0, 19) == 0) ? 300 : 16;
            announced  = 1'b0;
            c          = 0;
            form       = $urandom_range(0, 99);
            if (form < 50) begin
                if (cur_max_msg == 0) c = 0;
                else if (cur_max_msg <= 80 && $urandom_range(0, 6) == 0) c = cur_max_msg;
                else c = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 80)
                                                      : $urandom_range(0, 12);
                if (c > cur_max_msg) c = cur_max_msg;
                announced = 1'b1;
                line_bytes.push_back(CH_OPEN);
                push_decimal(64'(c), ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
                if ($urandom_range(0, 3) == 0) line_bytes.push_back(CH_PLUS);
                line_bytes.push_back(CH_CLOSE);
                // Stray LF and CR bytes ahead of the real CR LF do not hide it.
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
                repeat (n) line_bytes.push_back(CH_LF);
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0;
                repeat (n) line_bytes.push_back(CH_CR);
            end else if (form >= 80) begin
                line_bytes.push_back(CH_OPEN);
                case ($urandom_range(0, 6))
                    0: line_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                    1: ;
                    2: line_bytes.push_back(CH_PLUS);
                    3, 4, 5, 6: push_decimal(64'($urandom_range(0, 999)), 0);
                    default: ;
                endcase
                case ($urandom_range(0, 4))
                    // Something after the close brace.
                    0: begin
                        line_bytes.push_back(CH_CLOSE);
                        line_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                    end
                    // A lone CR, then another byte after the close brace.
                    1: begin
                        line_bytes.push_back(CH_CLOSE);
                        line_bytes.push_back(CH_CR);
                        line_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                    end
                    // A digit after the plus sign.
                    2: begin
                        line_bytes.push_back(CH_PLUS);
                        line_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                        line_bytes.push_back(CH_CLOSE);
                    end
                    // No close brace at all.
                    3: ;
                    // Close brace right after a letter, a brace or a bare plus.
                    4: begin
                        if (line_bytes.size() == 2 && line_bytes[1] >= CH_ZERO
                            && line_bytes[1] <= CH_NINE) line_bytes.push_back(8'h61);
                        line_bytes.push_back(CH_CLOSE);
                        line_bytes.push_back(CH_OPEN);
                    end
                    default: ;
                endcase
            end
            room = budget - line_bytes.size();
            if (room < 0) begin
                line_bytes.delete();
                announced = 1'b0;
                room = budget;
            end
            n = $urandom_range(0, (room < cap) ? room : cap);
            repeat (n) line_bytes.push_front(noise_byte());
            line_bytes.push_back(CH_CR);
            line_bytes.push_back(CH_LF);
            if (announced) repeat (c) line_bytes.push_back(8'($urandom_range(0, 255)));
            send_queue();
        end
    endtask

    task run_traffic(input int count);
        int start;
        begin
            start = bytes_sent;
            while (bytes_sent - start < count) send_message();
        end
    endtask

    // Output side: ready runs of random length with random stalls between.
    initial begin : sink_drive
        int n;
        forever begin
            m_axis_tready <= 1'b1;
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
            n = idle_cycles();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int pick;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_MAX_LINE;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes under the reset limits: an empty literal, an empty
        // line, a literal with a leading zero and plus sign hidden behind a
        // trailing CR whose bytes are CR LF, then a lone LF and both extreme
        // byte values inside a line.
        push_text("{0}\r\n\r\n{02+}\r\r\n\r\n\n");
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(8'h00);
        push_text("\r\n");
        send_queue();
        run_traffic(PHASE_ITEMS);

        // Only empty lines fit, and only empty literals pass.
        set_limits(16'd1, 32'd0);
        run_traffic(PHASE_ITEMS / 2);

        set_limits(16'hFFFF, 32'hFFFF_FFFF);
        run_traffic(PHASE_ITEMS);

        set_limits(16'($urandom_range(2, 8)), $urandom_range(0, 20));
        run_traffic(PHASE_ITEMS);

        set_limits(16'($urandom_range(20, 200)), 32'd0);
        run_traffic(PHASE_ITEMS);

        set_limits(16'($urandom_range(10, 400)), $urandom_range(1, 100));
        run_traffic(PHASE_ITEMS);

        // The failure is sticky until reset, so the run ends with one of the
        // terminal cases followed by bytes that must all be dropped, or by a
        // literal of the greatest count that swallows everything after it.
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            // Line too long.
            set_limits(16'($urandom_range(1, 12)), 32'd100);
            repeat (int'(cur_max_line) + 1)
                line_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end else if (pick == 1) begin
            // Literal too long: one above the limit, or at or past the digit saturation.
            pick = $urandom_range(0, 2);
            if (pick == 0) set_limits(16'd200, $urandom_range(0, 1000));
            else set_limits(16'd200, 32'hFFFF_FFFF);
            line_bytes.push_back(CH_OPEN);
            if (pick == 0) push_decimal({32'd0, cur_max_msg} + 64'd1, 0);
            else if (pick == 1) push_decimal(64'h1_0000_0000, 0);
            else repeat ($urandom_range(11, 14)) line_bytes.push_back(CH_NINE);
            line_bytes.push_back(CH_CLOSE);
            line_bytes.push_back(CH_CR);
            line_bytes.push_back(CH_LF);
        end else begin
            set_limits(16'hFFFF, 32'hFFFF_FFFF);
            push_text("{4294967295}\r\n");
        end
        repeat (30) line_bytes.push_back(8'($urandom_range(0, 255)));
        send_queue();

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
